@@ hw/rtl/s3mf_pkg.sv @@
`default_nettype none

package s3mf_pkg;

	// APB register file geometry
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// Register index, taken from paddr above the byte offset
	localparam logic [APB_AW-3:0] REG_GRID_SIZE = '0;

	// Grid side lower limit and reset side
	localparam int unsigned MIN_SIZE        = 3;
	localparam int unsigned GRID_SIZE_RESET = 3;

	// Window geometry
	localparam int unsigned WIN = 3;

endpackage

`default_nettype wire

@@ hw/rtl/s3mf_stream_if.sv @@
`default_nettype none

// Input sample channel
interface s3mf_sample_if #(
	parameter int SW = 16
);
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

// Result channel
interface s3mf_result_if #(
	parameter int SW = 16,
	parameter int CW = 10
);
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] window_max;
	logic        [CW-1:0] out_row;
	logic        [CW-1:0] out_col;
	logic                 row_end;
	logic                 grid_end;

	modport source (output valid, output window_max, output out_row, output out_col,
		output row_end, output grid_end, input ready);
	modport sink   (input valid, input window_max, input out_row, input out_col,
		input row_end, input grid_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/s3mf_regs.sv @@
`default_nettype none

module s3mf_regs
	import s3mf_pkg::*;
#(
	parameter int MAX_SIZE = 1024,
	parameter int GW       = 11,
	parameter int CW       = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic                   cfg_clr,
	output logic      [CW-1:0]     last_idx
);

	logic [GW-1:0] grid_size_q;
	logic [CW-1:0] last_idx_q;
	logic [GW-1:0] wdata;
	logic [CW-1:0] wr_last;
	logic          sel_grid;

	assign pready   = 1'b1;
	assign wdata    = pwdata[GW-1:0];
	assign sel_grid = (paddr[APB_AW-1:2] == REG_GRID_SIZE);
	assign cfg_clr  = psel & penable & pwrite & sel_grid;
	assign last_idx = last_idx_q;

	// Clamp the side into range and keep the last index n-1
	always_comb begin
		if (wdata < GW'(MIN_SIZE)) begin
			wr_last = CW'(MIN_SIZE - 1);
		end else if (wdata > GW'(MAX_SIZE)) begin
			wr_last = CW'(MAX_SIZE - 1);
		end else begin
			wr_last = CW'(wdata - GW'(1));
		end
	end

	// Hold the raw register and its clamped last index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GW'(GRID_SIZE_RESET);
			last_idx_q  <= CW'(GRID_SIZE_RESET - 1);
		end else if (cfg_clr) begin
			grid_size_q <= wdata;
			last_idx_q  <= wr_last;
		end
	end

	// Read back
	assign prdata = sel_grid ? APB_DW'(grid_size_q) : '0;

endmodule

`default_nettype wire

@@ hw/rtl/s3mf_line_buf.sv @@
`default_nettype none

module s3mf_line_buf #(
	parameter int DEPTH = 1024,
	parameter int SW    = 16,
	parameter int AW    = 10
) (
	input  wire logic                 clk,
	input  wire logic                 rd_en,
	input  wire logic        [AW-1:0] rd_addr,
	input  wire logic signed [SW-1:0] key,
	input  wire logic                 wb_en,
	input  wire logic        [AW-1:0] wb_addr,
	output logic signed      [SW-1:0] up_s1,
	output logic signed      [SW-1:0] mid_s1
);

	logic signed [SW-1:0] upper_mem  [DEPTH];
	logic signed [SW-1:0] middle_mem [DEPTH];

	// Read both rows and push the new sample into the middle row
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_s1               <= upper_mem[rd_addr];
			mid_s1              <= middle_mem[rd_addr];
			middle_mem[rd_addr] <= key;
		end
	end

	// Move the old middle sample up one row
	always_ff @(posedge clk) begin
		if (wb_en) begin
			upper_mem[wb_addr] <= mid_s1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/s3mf_window.sv @@
`default_nettype none

module s3mf_window
	import s3mf_pkg::*;
#(
	parameter int SW = 16,
	parameter int CW = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 v_s1,
	input  wire logic                 emit_s1,
	input  wire logic signed [SW-1:0] up_s1,
	input  wire logic signed [SW-1:0] mid_s1,
	input  wire logic signed [SW-1:0] key_s1,
	input  wire logic        [CW-1:0] row_s1,
	input  wire logic        [CW-1:0] col_s1,
	input  wire logic                 row_end_s1,
	input  wire logic                 grid_end_s1,
	output logic                      adv,
	s3mf_result_if.source             results
);

	logic signed [SW-1:0] win_q [WIN][WIN];
	logic signed [SW-1:0] cand  [9];
	logic signed [SW-1:0] lvl1  [4];
	logic signed [SW-1:0] lvl2  [2];
	logic signed [SW-1:0] best;
	logic                 valid_q;
	logic signed [SW-1:0] max_q;
	logic        [CW-1:0] row_q;
	logic        [CW-1:0] col_q;
	logic                 row_end_q;
	logic                 grid_end_q;

	function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
		input logic signed [SW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// Advance stage 1 when the result register is free or being drained
	assign adv = v_s1 && (!valid_q || results.ready);

	// Gather the window as it stands after this shift
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			cand[3*i]     = win_q[i][1];
			cand[3*i + 1] = win_q[i][2];
		end
		cand[2] = up_s1;
		cand[5] = mid_s1;
		cand[8] = key_s1;
	end

	// Compare tree
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lvl1[i] = smax(cand[2*i], cand[2*i + 1]);
		end
		for (int i = 0; i < 2; i++) begin
			lvl2[i] = smax(lvl1[2*i], lvl1[2*i + 1]);
		end
		best = smax(smax(lvl2[0], lvl2[1]), cand[8]);
	end

	// Shift the window one column
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < WIN; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up_s1;
			win_q[1][2] <= mid_s1;
			win_q[2][2] <= key_s1;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv && emit_s1) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv && emit_s1) begin
			max_q      <= best;
			row_q      <= row_s1 - CW'(2);
			col_q      <= col_s1 - CW'(2);
			row_end_q  <= row_end_s1;
			grid_end_q <= grid_end_s1;
		end
	end

	assign results.valid      = valid_q;
	assign results.window_max = max_q;
	assign results.out_row    = row_q;
	assign results.out_col    = col_q;
	assign results.row_end    = row_end_q;
	assign results.grid_end   = grid_end_q;

`ifndef SYNTH
	// A new result only comes from a stage-1 item
	a_rise_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(v_s1)) else $error("result without stage-1 item");

	// A stalled result holds its payload
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !results.ready |=> valid_q && $stable(max_q) && $stable(col_q))
		else $error("result changed under stall");

	// The end of a grid is also the end of a row
	a_grid_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && grid_end_q |-> row_end_q) else $error("grid end without row end");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sliding_3x3_max_filter.sv @@
`default_nettype none

// 3x3 sliding maximum filter over a square grid.
// Samples arrive on the samples channel in row-major order, one per
// transaction; the side length n is set through the APB register grid_size
// (byte address 0, clamped to 3..MAX_SIZE). Writing grid_size restarts the
// grid at row 0, column 0; write it only while the block is idle.
// For each sample at row >= 2 and column >= 2 one transaction leaves on the
// results channel: the signed maximum of the 3x3 window ending there, its
// position in the (n-2)x(n-2) result matrix, and row and grid end flags.
// Other samples produce no result. Counters wrap after n*n samples, so the
// next grid may follow immediately.
// Throughput: one sample per clock while results are taken. The accepting
// edge registers the line-store read and the sample in stage 1; when stage
// 1 advances, the window shifts and the 9-input compare tree loads the
// result register.
// When the receiver stalls, the result register holds, stage 1 holds, and
// samples.ready drops once stage 1 is occupied, until the result is taken.
// Reset clears the counters, the pipeline valids and sets grid_size to 3;
// line stores and window registers are not cleared, and no result reads an
// entry before it has been written.
module sliding_3x3_max_filter
	import s3mf_pkg::*;
#(
	parameter int MAX_SIZE     = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	s3mf_sample_if.sink            samples,
	s3mf_result_if.source          results
);

	localparam int CW = $clog2(MAX_SIZE);
	localparam int GW = $clog2(MAX_SIZE + 1);

	logic                           cfg_clr;
	logic        [CW-1:0]           last_idx;
	logic        [CW-1:0]           row_q;
	logic        [CW-1:0]           col_q;
	logic                           in_acc;
	logic                           adv;
	logic                           v_s1;
	logic signed [SAMPLE_WIDTH-1:0] key_s1;
	logic signed [SAMPLE_WIDTH-1:0] up_s1;
	logic signed [SAMPLE_WIDTH-1:0] mid_s1;
	logic        [CW-1:0]           row_s1;
	logic        [CW-1:0]           col_s1;
	logic                           emit_s1;
	logic                           row_end_s1;
	logic                           grid_end_s1;

	s3mf_regs #(
		.MAX_SIZE (MAX_SIZE),
		.GW       (GW),
		.CW       (CW)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg_clr  (cfg_clr),
		.last_idx (last_idx)
	);

	// Take a sample when stage 1 is empty or moving on
	assign samples.ready = !v_s1 || adv;
	assign in_acc        = samples.valid && samples.ready;

	// Advance the grid position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_clr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (col_q == last_idx) begin
				col_q <= '0;
				row_q <= (row_q == last_idx) ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload and position tags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_s1      <= samples.sample_value;
			row_s1      <= row_q;
			col_s1      <= col_q;
			emit_s1     <= (row_q > CW'(1)) && (col_q > CW'(1));
			row_end_s1  <= (col_q == last_idx);
			grid_end_s1 <= (col_q == last_idx) && (row_q == last_idx);
		end
	end

	s3mf_line_buf #(
		.DEPTH (MAX_SIZE),
		.SW    (SAMPLE_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.key     (samples.sample_value),
		.wb_en   (adv),
		.wb_addr (col_s1),
		.up_s1   (up_s1),
		.mid_s1  (mid_s1)
	);

	s3mf_window #(
		.SW (SAMPLE_WIDTH),
		.CW (CW)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s1        (v_s1),
		.emit_s1     (emit_s1),
		.up_s1       (up_s1),
		.mid_s1      (mid_s1),
		.key_s1      (key_s1),
		.row_s1      (row_s1),
		.col_s1      (col_s1),
		.row_end_s1  (row_end_s1),
		.grid_end_s1 (grid_end_s1),
		.adv         (adv),
		.results     (results)
	);

`ifndef SYNTH
	// Position stays inside the grid
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_idx && row_q <= last_idx) else $error("grid position out of range");

	// Upper-row write-back never hits the column being read
	a_wb_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && adv |-> col_q != col_s1) else $error("line store read/write clash");

	// A stalled stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(col_s1)) else $error("stage 1 item lost");
`endif

endmodule

`default_nettype wire

@@ dv/sliding_3x3_max_filter_tb.sv @@
module sliding_3x3_max_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import s3mf_pkg::*;

	localparam int MAX_SIDE     = 1024;
	localparam int SW           = 16;
	localparam int CW           = 10;
	localparam int IDLE_PCT     = 34;
	localparam int SETTLE       = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int WIDE_ITEMS   = 120;
	localparam int RANDOM_ITEMS = 450;

	// register indexes: grid_size, and one past the end of the map
	localparam logic [1:0] GRID_REG  = 2'(REG_GRID_SIZE);
	localparam logic [1:0] SPARE_REG = 2'd1;

	typedef struct packed {
		logic signed [SW-1:0] window_max;
		logic [CW-1:0]        out_row;
		logic [CW-1:0]        out_col;
		logic                 row_end;
		logic                 grid_end;
	} max_result_t;

	typedef enum logic {OP_SAMPLE, OP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [1:0]  reg_idx;
		logic [31:0] data;
		logic        typed;
		max_result_t want;
	} dir_step_t;

	localparam max_result_t NO_RESULT = '0;
	localparam max_result_t ONLY_HI   = '{16'sh7FFF, 10'd0, 10'd0, 1'b1, 1'b1};
	localparam max_result_t ONLY_LO   = '{16'sh8000, 10'd0, 10'd0, 1'b1, 1'b1};

	// Directed steps: a 3x3 grid split by a write to an unmapped register, a side
	// below range, a restart mid-grid, then a side above range for the long run.
	localparam dir_step_t DIRECTED_STEPS [24] = '{
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_0000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_FFFF, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_0001, 1'b0, NO_RESULT},
		'{OP_WRITE,  SPARE_REG, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_7FFF, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_5555, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_AAAA, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_0100, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b1, ONLY_HI},
		'{OP_WRITE,  GRID_REG,  32'h0000_0000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_0064, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_FF9C, 1'b0, NO_RESULT},
		'{OP_WRITE,  GRID_REG,  32'h0000_0002, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b0, NO_RESULT},
		'{OP_SAMPLE, GRID_REG,  32'h0000_8000, 1'b1, ONLY_LO},
		'{OP_WRITE,  GRID_REG,  32'hFFFF_FFFF, 1'b0, NO_RESULT}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	s3mf_sample_if #(.SW(SW))           smp_if ();
	s3mf_result_if #(.SW(SW), .CW(CW)) res_if ();

	sliding_3x3_max_filter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (smp_if.sink),
		.results (res_if.source)
	);

	// period 2 ns
	always #1 clk = ~clk;

	// filter state as seen from outside
	logic signed [SW-1:0] upper_line [MAX_SIDE];
	logic signed [SW-1:0] middle_line [MAX_SIDE];
	logic signed [SW-1:0] win [3][3];
	int unsigned          row_idx;
	int unsigned          col_idx;
	logic [10:0]          side_reg;

	max_result_t expected_maxima [$];
	int          mismatches = 0;
	int          send_idle = IDLE_PCT;
	int          recv_idle = IDLE_PCT;
	bit          hold_req = 1'b0;
	int          quiet_cycles = 0;

	function automatic int unsigned side_len();
		if (side_reg < MIN_SIZE)
			return MIN_SIZE;
		if (side_reg > MAX_SIDE)
			return MAX_SIDE;
		return side_reg;
	endfunction

	// Shift one sample into the line stores and window; return 1 with the
	// window maximum when the sample closes a full 3x3 window.
	function automatic bit slide_window(input logic signed [SW-1:0] s, output max_result_t res);
		int unsigned          n;
		int unsigned          r;
		int unsigned          c;
		logic signed [SW-1:0] up;
		logic signed [SW-1:0] mid;
		logic signed [SW-1:0] best;
		bit                   hit;
		n   = side_len();
		r   = row_idx;
		c   = col_idx;
		hit = 1'b0;
		res = '0;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		up             = upper_line[c];
		mid            = middle_line[c];
		upper_line[c]  = mid;
		middle_line[c] = s;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = s;
		if (r >= 2 && c >= 2) begin
			best = win[0][0];
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					if (win[i][j] > best)
						best = win[i][j];
			res.window_max = best;
			res.out_row    = CW'(r - 2);
			res.out_col    = CW'(c - 2);
			res.row_end    = (c == n - 1);
			res.grid_end   = (c == n - 1) && (r == n - 1);
			hit            = 1'b1;
		end
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n)
				r = 0;
		end
		row_idx = r;
		col_idx = c;
		return hit;
	endfunction

	// mostly random samples, with the extremes mixed in
	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return SW'($urandom);
		endcase
	endfunction

	// Drop valid and hold until every expected transaction has come and the
	// pipeline has drained.
	task automatic wait_idle();
		smp_if.valid <= 1'b0;
		while (expected_maxima.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// a grid_size write restarts the grid; other indexes are ignored
		if (idx == GRID_REG) begin
			side_reg = data[10:0];
			row_idx  = 0;
			col_idx  = 0;
		end
	endtask

	task automatic send_sample(input logic signed [SW-1:0] v, input bit typed,
		input max_result_t want);
		max_result_t got;
		bit          hit;
		while ($urandom_range(99) < send_idle) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid        <= 1'b1;
		smp_if.sample_value <= v;
		do @(posedge clk); while (!smp_if.ready);
		hit = slide_window(v, got);
		if (typed)
			expected_maxima.push_back(want);
		else if (hit)
			expected_maxima.push_back(got);
	endtask

	// Result side: random backpressure, or one long hold-off on request
	initial begin : drive_ready
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		max_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_maxima.size() == 0) begin
				$error("unexpected result: window_max %0d out_row %0d out_col %0d",
					res_if.window_max, res_if.out_row, res_if.out_col);
				mismatches++;
			end else begin
				want = expected_maxima.pop_front();
				if (res_if.window_max !== want.window_max) begin
					$error("window_max: expected %0d, got %0d", want.window_max,
						res_if.window_max);
					mismatches++;
				end
				if (res_if.out_row !== want.out_row) begin
					$error("out_row: expected %0d, got %0d", want.out_row, res_if.out_row);
					mismatches++;
				end
				if (res_if.out_col !== want.out_col) begin
					$error("out_col: expected %0d, got %0d", want.out_col, res_if.out_col);
					mismatches++;
				end
				if (res_if.row_end !== want.row_end) begin
					$error("row_end: expected %0d, got %0d", want.row_end, res_if.row_end);
					mismatches++;
				end
				if (res_if.grid_end !== want.grid_end) begin
					$error("grid_end: expected %0d, got %0d", want.grid_end,
						res_if.grid_end);
					mismatches++;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		dir_step_t   st;
		int unsigned random_sent;
		int unsigned count;
		int unsigned n;
		int unsigned break_at;
		int unsigned phase;
		logic [31:0] data;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		smp_if.valid        = 1'b0;
		smp_if.sample_value = '0;
		upper_line          = '{default: '0};
		middle_line         = '{default: '0};
		win                 = '{default: '{default: '0}};
		row_idx             = 0;
		col_idx             = 0;
		side_reg            = 11'(GRID_SIZE_RESET);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (DIRECTED_STEPS[k]) begin
			st = DIRECTED_STEPS[k];
			if (st.kind == OP_WRITE)
				write_reg(st.reg_idx, st.data);
			else
				send_sample(st.data[SW-1:0], st.typed, st.want);
		end

		// widest grid, first row only: no result may appear
		repeat (WIDE_ITEMS)
			send_sample(pick_sample(), 1'b0, NO_RESULT);

		// hold off results while samples keep coming, so the input stalls
		write_reg(GRID_REG, 32'd6);
		send_idle = 0;
		hold_req  = 1'b1;
		repeat (100) send_sample(pick_sample(), 1'b0, NO_RESULT);

		// long stretch with no idling on either side
		recv_idle = 0;
		repeat (150) send_sample(pick_sample(), 1'b0, NO_RESULT);
		send_idle = IDLE_PCT;
		recv_idle = IDLE_PCT;

		// random grids, mostly small, sometimes cut short by a register write
		random_sent = 0;
		phase       = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: n = $urandom_range(2);
				1: n = MIN_SIZE;
				default: n = $urandom_range(MIN_SIZE, 12);
			endcase
			data       = $urandom;
			data[10:0] = 11'(n);
			write_reg(GRID_REG, data);
			send_idle = (phase % 5 == 2) ? 0 : IDLE_PCT;
			recv_idle = send_idle;
			count     = $urandom_range(1, 3 * side_len() * side_len());
			break_at  = $urandom_range(0, 2 * count);
			for (int unsigned i = 0; i < count; i++) begin
				if (i == break_at) begin
					if ($urandom_range(1))
						write_reg(SPARE_REG, $urandom);
					else
						write_reg(GRID_REG, data);
				end
				send_sample(pick_sample(), 1'b0, NO_RESULT);
			end
			random_sent += count;
			phase++;
		end

		// drain and report
		wait_idle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
